/* sv/lcd_rect_fill_serializer_core_macros.svh */
// ----------------------------------------------------------------------------
// lcd_rect_fill_serializer_core_macros.svh
// Assertion macros shared by the rectangle fill serializer queue and back modules.
// ----------------------------------------------------------------------------
`ifndef LCD_RECT_FILL_SERIALIZER_CORE_MACROS_SVH
`define LCD_RECT_FILL_SERIALIZER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define LRF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and held off during reset.
`define LRF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/lrf_pkg.sv */
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared constants and types of the rectangle fill serializer.
// ----------------------------------------------------------------------------
package lrf_pkg;

	// Panel size in pixels.
	localparam int PANEL_COLUMNS = 240;
	localparam int PANEL_ROWS    = 320;

	// Widths of clipped lengths and of the pixel count.
	localparam int COL_LEN_W = $clog2(PANEL_COLUMNS + 1);
	localparam int ROW_LEN_W = $clog2(PANEL_ROWS + 1);
	localparam int PIX_W     = $clog2(PANEL_COLUMNS * PANEL_ROWS + 1);

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Item actions.
	localparam logic ACTION_START = 1'b0;
	localparam logic ACTION_PULL  = 1'b1;

	// Start status codes.
	localparam logic [1:0] STATUS_NONE     = 2'd0;
	localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
	localparam logic [1:0] STATUS_OFF      = 2'd2;
	localparam logic [1:0] STATUS_BUSY     = 2'd3;

	// Panel commands.
	localparam logic [7:0] CMD_COL_WINDOW = 8'h2A;
	localparam logic [7:0] CMD_ROW_WINDOW = 8'h2B;
	localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

	// Classified item after clipping, before the pixel count is formed.
	typedef struct packed {
		logic                 start;
		logic                 off;
		logic [15:0]          col_start;
		logic [15:0]          col_end;
		logic [15:0]          row_start;
		logic [15:0]          row_end;
		logic [15:0]          color;
		logic [COL_LEN_W-1:0] col_len;
		logic [ROW_LEN_W-1:0] row_len;
	} lrf_clip_t;

	// Item as it travels through the queue to the back.
	typedef struct packed {
		logic             start;
		logic             off;
		logic [15:0]      col_start;
		logic [15:0]      col_end;
		logic [15:0]      row_start;
		logic [15:0]      row_end;
		logic [15:0]      color;
		logic [PIX_W-1:0] pixels;
	} lrf_item_t;

endpackage

/* sv/lrf_front.sv */
// ----------------------------------------------------------------------------
// lrf_front
// Accepts input items, clips the rectangle to the panel and forms the pixel
// count before handing the item to the queue.
// ----------------------------------------------------------------------------
module lrf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic [15:0]          rect_col,
	input  logic [15:0]          rect_row,
	input  logic [15:0]          rect_width,
	input  logic [15:0]          rect_height,
	input  logic [15:0]          fill_color,
	output logic                 push_valid,
	input  logic                 push_ready,
	output lrf_pkg::lrf_item_t   push_item
);

	localparam logic [15:0] COLS16 = 16'(lrf_pkg::PANEL_COLUMNS);
	localparam logic [15:0] ROWS16 = 16'(lrf_pkg::PANEL_ROWS);

	logic              s1_valid_q;
	lrf_pkg::lrf_clip_t s1_item_s1;
	lrf_pkg::lrf_clip_t clip_d;
	logic [16:0]       col_sum;
	logic [16:0]       row_sum;
	logic [15:0]       col_len16;
	logic [15:0]       row_len16;
	logic              in_xfer;

	assign in_ready = !s1_valid_q || push_ready;
	assign in_xfer  = in_valid && in_ready;

	// Clip width and height to the panel edge and form the window ends.
	always_comb begin
		col_sum   = {1'b0, rect_col} + {1'b0, rect_width};
		row_sum   = {1'b0, rect_row} + {1'b0, rect_height};
		col_len16 = (col_sum > {1'b0, COLS16}) ? (COLS16 - rect_col) : rect_width;
		row_len16 = (row_sum > {1'b0, ROWS16}) ? (ROWS16 - rect_row) : rect_height;
		clip_d.start     = (action == lrf_pkg::ACTION_START);
		clip_d.off       = (rect_col >= COLS16) || (rect_row >= ROWS16);
		clip_d.col_start = rect_col;
		clip_d.col_end   = rect_col + col_len16 - 16'd1;
		clip_d.row_start = rect_row;
		clip_d.row_end   = rect_row + row_len16 - 16'd1;
		clip_d.color     = fill_color;
		clip_d.col_len   = col_len16[lrf_pkg::COL_LEN_W-1:0];
		clip_d.row_len   = row_len16[lrf_pkg::ROW_LEN_W-1:0];
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			s1_item_s1 <= clip_d;
		end
	end

	// Pixel count and hand-off to the queue.
	always_comb begin
		push_item.start     = s1_item_s1.start;
		push_item.off       = s1_item_s1.off;
		push_item.col_start = s1_item_s1.col_start;
		push_item.col_end   = s1_item_s1.col_end;
		push_item.row_start = s1_item_s1.row_start;
		push_item.row_end   = s1_item_s1.row_end;
		push_item.color     = s1_item_s1.color;
		push_item.pixels    = lrf_pkg::PIX_W'(s1_item_s1.col_len) *
			lrf_pkg::PIX_W'(s1_item_s1.row_len);
	end

	assign push_valid = s1_valid_q;

endmodule

/* sv/lrf_queue.sv */
// ----------------------------------------------------------------------------
// lrf_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`include "lcd_rect_fill_serializer_core_macros.svh"

module lrf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  lrf_pkg::lrf_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output lrf_pkg::lrf_item_t pop_item
);

	localparam logic [lrf_pkg::QCNT_W-1:0] DEPTH_CNT = lrf_pkg::QCNT_W'(lrf_pkg::QUEUE_DEPTH);
	localparam logic [lrf_pkg::QPTR_W-1:0] LAST_PTR  =
		lrf_pkg::QPTR_W'(lrf_pkg::QUEUE_DEPTH - 1);

	lrf_pkg::lrf_item_t              slot_q [lrf_pkg::QUEUE_DEPTH];
	logic [lrf_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [lrf_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [lrf_pkg::QCNT_W-1:0]      count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = (count_q != DEPTH_CNT);
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// The fill count never runs past the depth.
	`LRF_ASSERT_SAME(a_count_bound, 1'b1, count_q <= DEPTH_CNT, "queue count over depth")

endmodule

/* sv/lrf_back.sv */
// ----------------------------------------------------------------------------
// lrf_back
// Holds the rectangle state, carries out starts and pulls in order and
// keeps the result in an output register.
// ----------------------------------------------------------------------------
`include "lcd_rect_fill_serializer_core_macros.svh"

module lrf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  lrf_pkg::lrf_item_t pop_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               has_byte,
	output logic [7:0]         link_byte,
	output logic               is_data,
	output logic               last_byte,
	output logic [1:0]         start_status,
	output logic               busy_res
);

	// Header byte positions; the pixel phase follows the memory-write command.
	localparam logic [3:0] STEP_COL_CMD   = 4'd0;
	localparam logic [3:0] STEP_COL_SHI   = 4'd1;
	localparam logic [3:0] STEP_COL_SLO   = 4'd2;
	localparam logic [3:0] STEP_COL_EHI   = 4'd3;
	localparam logic [3:0] STEP_COL_ELO   = 4'd4;
	localparam logic [3:0] STEP_ROW_CMD   = 4'd5;
	localparam logic [3:0] STEP_ROW_SHI   = 4'd6;
	localparam logic [3:0] STEP_ROW_SLO   = 4'd7;
	localparam logic [3:0] STEP_ROW_EHI   = 4'd8;
	localparam logic [3:0] STEP_ROW_ELO   = 4'd9;
	localparam logic [3:0] STEP_MEM_CMD   = 4'd10;
	localparam logic [3:0] STEP_PIXELS    = 4'd11;

	logic                     busy_q;
	logic [3:0]               step_q;
	logic [15:0]              col_start_q;
	logic [15:0]              col_end_q;
	logic [15:0]              row_start_q;
	logic [15:0]              row_end_q;
	logic [15:0]              color_q;
	logic [lrf_pkg::PIX_W-1:0] pixels_q;
	logic                     low_half_q;
	logic                     out_valid_q;

	logic                     busy_d;
	logic [3:0]               step_d;
	logic [lrf_pkg::PIX_W-1:0] pixels_d;
	logic                     low_half_d;
	logic                     load;
	logic                     n_has;
	logic [7:0]               n_byte;
	logic                     n_data;
	logic                     n_last;
	logic [1:0]               n_status;
	logic                     fire;

	assign pop_ready = !out_valid_q || out_ready;
	assign fire      = pop_valid && pop_ready;
	assign out_valid = out_valid_q;

	// Next state and result for the item at the head of the queue.
	always_comb begin
		busy_d     = busy_q;
		step_d     = step_q;
		pixels_d   = pixels_q;
		low_half_d = low_half_q;
		load       = 1'b0;
		n_has      = 1'b0;
		n_byte     = 8'h00;
		n_data     = 1'b0;
		n_last     = 1'b0;
		n_status   = lrf_pkg::STATUS_NONE;
		if (pop_item.start) begin
			if (busy_q) begin
				n_status = lrf_pkg::STATUS_BUSY;
			end else if (pop_item.off) begin
				n_status = lrf_pkg::STATUS_OFF;
			end else begin
				load       = 1'b1;
				busy_d     = 1'b1;
				step_d     = STEP_COL_CMD;
				pixels_d   = pop_item.pixels;
				low_half_d = 1'b0;
				n_status   = lrf_pkg::STATUS_ACCEPTED;
			end
		end else if (busy_q) begin
			n_has  = 1'b1;
			n_data = 1'b1;
			if (step_q < STEP_PIXELS) begin
				case (step_q)
					STEP_COL_CMD: begin
						n_byte = lrf_pkg::CMD_COL_WINDOW;
						n_data = 1'b0;
					end
					STEP_COL_SHI: n_byte = col_start_q[15:8];
					STEP_COL_SLO: n_byte = col_start_q[7:0];
					STEP_COL_EHI: n_byte = col_end_q[15:8];
					STEP_COL_ELO: n_byte = col_end_q[7:0];
					STEP_ROW_CMD: begin
						n_byte = lrf_pkg::CMD_ROW_WINDOW;
						n_data = 1'b0;
					end
					STEP_ROW_SHI: n_byte = row_start_q[15:8];
					STEP_ROW_SLO: n_byte = row_start_q[7:0];
					STEP_ROW_EHI: n_byte = row_end_q[15:8];
					STEP_ROW_ELO: n_byte = row_end_q[7:0];
					STEP_MEM_CMD: begin
						n_byte = lrf_pkg::CMD_MEM_WRITE;
						n_data = 1'b0;
						n_last = (pixels_q == '0);
					end
					default: n_byte = 8'h00;
				endcase
				step_d = step_q + 4'd1;
			end else if (!low_half_q) begin
				n_byte     = color_q[15:8];
				low_half_d = 1'b1;
			end else begin
				n_byte     = color_q[7:0];
				low_half_d = 1'b0;
				if (pixels_q != '0) begin
					pixels_d = pixels_q - 1'b1;
				end
				n_last = (pixels_d == '0);
			end
			if (n_last) begin
				busy_d     = 1'b0;
				step_d     = STEP_COL_CMD;
				low_half_d = 1'b0;
			end
		end
	end

	// Control state and output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= STEP_COL_CMD;
			pixels_q    <= '0;
			low_half_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				busy_q     <= busy_d;
				step_q     <= step_d;
				pixels_q   <= pixels_d;
				low_half_q <= low_half_d;
			end
			if (pop_ready) begin
				out_valid_q <= pop_valid;
			end
		end
	end

	// Window and color held for the running rectangle.
	always_ff @(posedge clk) begin
		if (fire && load) begin
			col_start_q <= pop_item.col_start;
			col_end_q   <= pop_item.col_end;
			row_start_q <= pop_item.row_start;
			row_end_q   <= pop_item.row_end;
			color_q     <= pop_item.color;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (fire) begin
			has_byte     <= n_has;
			link_byte    <= n_byte;
			is_data      <= n_data;
			last_byte    <= n_last;
			start_status <= n_status;
			busy_res     <= busy_d;
		end
	end

	// The header step never passes the pixel phase.
	`LRF_ASSERT_SAME(a_step_range, 1'b1, step_q <= STEP_PIXELS, "header step out of range")
	// An idle block sits at the first header byte with the high color half next.
	`LRF_ASSERT_SAME(a_idle_clean, !busy_q, step_q == STEP_COL_CMD && !low_half_q, "idle state not clean")
	// A last byte ends the rectangle.
	`LRF_ASSERT_NEXT(a_last_ends, fire && n_last, !busy_q && busy_res == 1'b0, "last byte left block busy")

endmodule

/* sv/lcd_rect_fill_serializer_core.sv */
// ----------------------------------------------------------------------------
// lcd_rect_fill_serializer_core
// Turns rectangle fill requests into the command and data byte stream of a
// TFT panel link, one byte per pull item.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | into core | in_valid / in_ready  | action, rect_col, rect_row,
//          |           |                      | rect_width, rect_height, fill_color
//  out     | from core | out_valid / out_ready| has_byte, link_byte, is_data,
//          |           |                      | last_byte, start_status, busy_res
//
// One item is accepted per cycle while in_ready is high; after its transfer each item's
// result is registered by the clip stage, which loads at the transfer, then the queue
// (pixel count multiply in between), and the back output register. The back executes
// one queued item per cycle unless the output stalls; its state update is the loop.
// Reset clears the valid bits, the queue and the rectangle state at once.
// A stalled output fills the two-entry queue, then the clip stage, then drops in_ready.
// ----------------------------------------------------------------------------
module lcd_rect_fill_serializer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [15:0] rect_col,
	input  logic [15:0] rect_row,
	input  logic [15:0] rect_width,
	input  logic [15:0] rect_height,
	input  logic [15:0] fill_color,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        has_byte,
	output logic [7:0]  link_byte,
	output logic        is_data,
	output logic        last_byte,
	output logic [1:0]  start_status,
	output logic        busy_res
);

	logic               push_valid;
	logic               push_ready;
	lrf_pkg::lrf_item_t push_item;
	logic               pop_valid;
	logic               pop_ready;
	lrf_pkg::lrf_item_t pop_item;

	// Front: accept and classify.
	lrf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.rect_col    (rect_col),
		.rect_row    (rect_row),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.fill_color  (fill_color),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_item   (push_item)
	);

	// Queue between the two halves.
	lrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Back: execute and emit bytes.
	lrf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.has_byte     (has_byte),
		.link_byte    (link_byte),
		.is_data      (is_data),
		.last_byte    (last_byte),
		.start_status (start_status),
		.busy_res     (busy_res)
	);

endmodule
